[hdl/deq_pkg.sv]
// shared constants for the double-ended queue: field widths, operation
// codes and error codes
// no dependencies
package deq_pkg;

  localparam int MODE_W  = 3;
  localparam int VALUE_W = 8;
  localparam int COUNT_W = 5;
  localparam int ERR_W   = 2;

  localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd1;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd4;
  localparam logic [MODE_W-1:0] MODE_QUERY      = 3'd5;

  localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
  localparam logic [ERR_W-1:0] ERR_UNDERFLOW = 2'd1;
  localparam logic [ERR_W-1:0] ERR_OVERFLOW  = 2'd2;

endpackage

[hdl/deq_in_if.sv]
// operation channel of the double-ended queue: valid/ready plus one word
// depends on deq_pkg
interface deq_in_if import deq_pkg::*;;
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

[hdl/deq_out_if.sv]
// result channel of the double-ended queue: valid/ready plus one word
// depends on deq_pkg
interface deq_out_if import deq_pkg::*;;
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] front_value;
  logic [VALUE_W-1:0] back_value;
  logic               has_items;
  logic [COUNT_W-1:0] item_count;
  logic [ERR_W-1:0]   error_code;

  modport source (output valid, output front_value, output back_value,
                  output has_items, output item_count, output error_code,
                  input ready);
  modport sink   (input valid, input front_value, input back_value,
                  input has_items, input item_count, input error_code,
                  output ready);
endinterface

[hdl/deq_ram.sv]
// generic synchronous ram: one write port, two registered read ports
// read-during-write to the same entry returns the old data
// no dependencies
module deq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  output logic [WIDTH-1:0]         rd_data_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

[hdl/double_ended_queue.sv]
// double-ended queue top level: pointer logic around one dual-read ram
// depends on deq_pkg, deq_in_if, deq_out_if, deq_ram
//
// A fixed-capacity double-ended queue held in a circular ram with head and
// tail pointers and an occupancy count. Each input word carries one
// operation (push back, push front, pop front, pop back, clear, query;
// codes 6 and 7 act as query) and gives exactly one result word with the
// front and back elements after the operation (zero when empty), a
// non-empty flag, the count and an error code (underflow on a pop when
// empty, overflow on a push when full; the failed operation changes
// nothing). Pointers and count update at the edge that accepts the word,
// together with the write of a pushed element and the reads of the new
// front and back entries; the ram returns those after that edge and the
// result lands in the output register at the first later edge at which
// that register is free, which raises out valid. The next word is taken
// at the same edge that loads the output register, so the block sustains
// one word per cycle while the result side keeps ready high; the result
// waits on the registered read of the ram. A stalled result holds the
// input off once one further word is in flight. A just-pushed element is
// forwarded around the ram. The ram needs no clearing after reset.
module double_ended_queue import deq_pkg::*; #(
  parameter int CAPACITY      = 16,
  parameter int ELEMENT_WIDTH = 8
) (
  input logic             clk,
  input logic             rst_n,
  deq_in_if.sink          in_ch,
  deq_out_if.source       out_ch
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] i);
    return (i == LAST_IDX) ? '0 : i + AW'(1);
  endfunction

  function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] i);
    return (i == '0) ? LAST_IDX : i - AW'(1);
  endfunction

  logic [AW-1:0]            head_r, head_nxt;
  logic [AW-1:0]            tail_r, tail_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic [ERR_W-1:0]         err_nxt, err_r;
  logic                     busy_r;
  logic                     fwd_front_r, fwd_back_r;
  logic [ELEMENT_WIDTH-1:0] push_val, push_val_r;
  logic                     push_ok;
  logic [AW-1:0]            wr_addr;
  logic [AW-1:0]            rd_addr_back;
  logic [ELEMENT_WIDTH-1:0] rd_front, rd_back;
  logic [ELEMENT_WIDTH-1:0] front_elem, back_elem;
  logic                     acc, load;

  logic               out_valid_r;
  logic [VALUE_W-1:0] front_value_r, back_value_r;
  logic               has_items_r;
  logic [COUNT_W-1:0] item_count_r;
  logic [ERR_W-1:0]   error_code_r;

  // the in-flight result moves to the output register when it is free
  assign load        = busy_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !busy_r || load;
  assign acc         = in_ch.valid && in_ch.ready;
  assign push_val    = ELEMENT_WIDTH'(in_ch.value);

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    err_nxt   = ERR_NONE;
    push_ok   = 1'b0;
    wr_addr   = tail_r;
    unique case (in_ch.mode)
      MODE_PUSH_BACK: begin
        if (count_r == FULL_CNT) begin
          err_nxt = ERR_OVERFLOW;
        end else begin
          push_ok   = 1'b1;
          wr_addr   = tail_r;
          tail_nxt  = wrap_inc(tail_r);
          count_nxt = count_r + CW'(1);
        end
      end
      MODE_PUSH_FRONT: begin
        if (count_r == FULL_CNT) begin
          err_nxt = ERR_OVERFLOW;
        end else begin
          push_ok   = 1'b1;
          head_nxt  = wrap_dec(head_r);
          wr_addr   = wrap_dec(head_r);
          count_nxt = count_r + CW'(1);
        end
      end
      MODE_POP_FRONT: begin
        if (count_r == '0) begin
          err_nxt = ERR_UNDERFLOW;
        end else begin
          head_nxt  = wrap_inc(head_r);
          count_nxt = count_r - CW'(1);
        end
      end
      MODE_POP_BACK: begin
        if (count_r == '0) begin
          err_nxt = ERR_UNDERFLOW;
        end else begin
          tail_nxt  = wrap_dec(tail_r);
          count_nxt = count_r - CW'(1);
        end
      end
      MODE_CLEAR: begin
        head_nxt  = '0;
        tail_nxt  = '0;
        count_nxt = '0;
      end
      default: begin
        // query and unused codes leave everything alone
      end
    endcase
  end

  assign rd_addr_back = wrap_dec(tail_nxt);

  deq_ram #(
    .WIDTH (ELEMENT_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk       (clk),
    .wr_en     (acc && push_ok),
    .wr_addr   (wr_addr),
    .wr_data   (push_val),
    .rd_en     (acc),
    .rd_addr_a (head_nxt),
    .rd_data_a (rd_front),
    .rd_addr_b (rd_addr_back),
    .rd_data_b (rd_back)
  );

  // the ram returns old data for an entry written in the same cycle
  assign front_elem = fwd_front_r ? push_val_r : rd_front;
  assign back_elem  = fwd_back_r  ? push_val_r : rd_back;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        head_r      <= head_nxt;
        tail_r      <= tail_nxt;
        count_r     <= count_nxt;
        err_r       <= err_nxt;
        push_val_r  <= push_val;
        fwd_front_r <= push_ok && (wr_addr == head_nxt);
        fwd_back_r  <= push_ok && (wr_addr == rd_addr_back);
      end
      if (acc) begin
        busy_r <= 1'b1;
      end else if (load) begin
        busy_r <= 1'b0;
      end
      if (load) begin
        out_valid_r   <= 1'b1;
        front_value_r <= (count_r != '0) ? VALUE_W'(front_elem) : '0;
        back_value_r  <= (count_r != '0) ? VALUE_W'(back_elem) : '0;
        has_items_r   <= (count_r != '0);
        item_count_r  <= COUNT_W'(count_r);
        error_code_r  <= err_r;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.front_value = front_value_r;
  assign out_ch.back_value  = back_value_r;
  assign out_ch.has_items   = has_items_r;
  assign out_ch.item_count  = item_count_r;
  assign out_ch.error_code  = error_code_r;

endmodule

[hdl/deq_checker.sv]
// port-level checks for the double-ended queue, bound to the top level
// depends on deq_pkg and double_ended_queue
module deq_checker import deq_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [VALUE_W-1:0] front_value,
  input logic [VALUE_W-1:0] back_value,
  input logic               has_items,
  input logic [COUNT_W-1:0] item_count,
  input logic [ERR_W-1:0]   error_code
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(front_value) &&
      $stable(back_value) && $stable(item_count) && $stable(error_code))
    else $error("result word changed while stalled");

  // a nonzero count always comes with the flag set (checked for the default capacity range)
  a_flag_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (item_count != '0) |-> has_items)
    else $error("nonzero count without has_items");

  // an empty deque shows zero elements
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !has_items |-> front_value == '0 && back_value == '0 &&
      item_count == '0)
    else $error("empty deque shows data");

  // underflow only happens on an empty deque, and leaves it empty
  a_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (error_code == ERR_UNDERFLOW) |-> !has_items)
    else $error("underflow reported with items held");

endmodule

bind double_ended_queue deq_checker u_deq_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .front_value (out_ch.front_value),
  .back_value  (out_ch.back_value),
  .has_items   (out_ch.has_items),
  .item_count  (out_ch.item_count),
  .error_code  (out_ch.error_code)
);
